// File: src/rgba_image_diff_mask_unit_assert.svh
// Assertion macros for the RGBA image difference mask unit.
`ifndef RGBA_IMAGE_DIFF_MASK_UNIT_ASSERT_SVH
`define RGBA_IMAGE_DIFF_MASK_UNIT_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define RIDM_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ridm assertion failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define RIDM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ridm assertion failed");

`endif

// File: src/ridm_pkg.sv
// Types and constants for the RGBA image difference mask unit.
`default_nettype none

package ridm_pkg;

   localparam int BAD_TOTAL_W = 25;
   localparam int ABS_TOTAL_W = 34;

   localparam logic [63:0] MAX_PIXELS    = 64'd16777216;
   localparam logic [63:0] BAD_WIDTH_MAX = 64'h1FF_FFFF;
   localparam logic [63:0] ABS_WIDTH_MAX = 64'h3_FFFF_FFFF;

   // Saturation limits, clipped to what each total field can hold
   localparam logic [63:0] BAD_LIMIT =
      (MAX_PIXELS > BAD_WIDTH_MAX) ? BAD_WIDTH_MAX : MAX_PIXELS;
   localparam logic [63:0] ABS_LIMIT =
      ((MAX_PIXELS * 64'd765) > ABS_WIDTH_MAX) ? ABS_WIDTH_MAX : (MAX_PIXELS * 64'd765);
   localparam logic [BAD_TOTAL_W-1:0] BAD_CAP = BAD_LIMIT[BAD_TOTAL_W-1:0];
   localparam logic [ABS_TOTAL_W-1:0] ABS_CAP = ABS_LIMIT[ABS_TOTAL_W-1:0];

   localparam logic [7:0] THRESHOLD_RESET = 8'd8;
   localparam logic [7:0] MISMATCH_RED    = 8'd255;

   // Divide by six: (x * 683) >> 12 is exact for x below 2048
   localparam logic [9:0] GREY_RECIP = 10'd683;
   localparam int         GREY_SHIFT = 12;

   typedef struct packed {
      logic [7:0] a_red;
      logic [7:0] a_green;
      logic [7:0] a_blue;
      logic [7:0] a_alpha;
      logic [7:0] b_red;
      logic [7:0] b_green;
      logic [7:0] b_blue;
      logic [7:0] b_alpha;
      logic       frame_last;
   } req_payload_type;

   typedef struct packed {
      logic [7:0]             out_red;
      logic [7:0]             out_green;
      logic [7:0]             out_blue;
      logic                   pixel_bad;
      logic                   end_of_frame;
      logic [BAD_TOTAL_W-1:0] bad_total;
      logic [ABS_TOTAL_W-1:0] abs_total;
   } rsp_payload_type;

endpackage

`default_nettype wire

// File: src/rgba_image_diff_mask_unit.sv
// Top level of the RGBA image difference mask unit.
//
//   channel | ports                      | direction | moves
//   --------+----------------------------+-----------+---------------------------
//   req     | req_valid/req_ready/req_data | in      | one pixel pair per transfer
//   rsp     | rsp_valid/rsp_ready/rsp_data | out     | one mask pixel and totals
//   csr     | csr_wr_en/csr_wr_data      | in        | threshold write, no wait
//
// One pixel per clock sustained while rsp_ready is high; a req transfer goes
// through the input register and then the result register before rsp_valid
// rises. Totals advance as an item enters the result register.
// A stalled rsp holds the result register; the input register takes one more
// item, then req_ready drops until the result is transferred.
// Synchronous reset clears valids, totals and the threshold (to 8).
`default_nettype none

`include "rgba_image_diff_mask_unit_assert.svh"

module rgba_image_diff_mask_unit
   import ridm_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   input  wire req_payload_type req_data,
   output logic                 rsp_valid,
   input  wire logic            rsp_ready,
   output rsp_payload_type      rsp_data,
   input  wire logic            csr_wr_en,
   input  wire logic [7:0]      csr_wr_data
);

   // Configuration
   logic [7:0] threshold_ff;

   // Input register
   logic            s1_valid_ff;
   req_payload_type s1_data_ff;

   // Result register
   logic            rsp_valid_ff;
   rsp_payload_type rsp_data_ff;
   rsp_payload_type rsp_data_in;

   // Running totals for the current frame
   logic [BAD_TOTAL_W-1:0] bad_count_ff;
   logic [BAD_TOTAL_W-1:0] bad_count_in;
   logic [ABS_TOTAL_W-1:0] abs_sum_ff;
   logic [ABS_TOTAL_W-1:0] abs_sum_in;

   logic       advance;
   logic [7:0] diff_red;
   logic [7:0] diff_green;
   logic [7:0] diff_blue;
   logic [7:0] diff_alpha;
   logic       bad;
   logic [9:0] b_sum;
   logic [19:0] grey_prod;
   logic [7:0] grey;
   logic [9:0] diff_sum;
   logic [ABS_TOTAL_W-1:0] abs_raw;

   function automatic logic [7:0] abs_diff(input logic [7:0] x, input logic [7:0] y);
      abs_diff = (x > y) ? (x - y) : (y - x);
   endfunction

   // Move the held item on whenever the result register is free or being taken
   assign advance   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      diff_red   = abs_diff(s1_data_ff.a_red,   s1_data_ff.b_red);
      diff_green = abs_diff(s1_data_ff.a_green, s1_data_ff.b_green);
      diff_blue  = abs_diff(s1_data_ff.a_blue,  s1_data_ff.b_blue);
      diff_alpha = abs_diff(s1_data_ff.a_alpha, s1_data_ff.b_alpha);

      // Alpha can flag a mismatch but never enters the difference sum
      bad = (diff_red > threshold_ff) || (diff_green > threshold_ff) ||
            (diff_blue > threshold_ff) || (diff_alpha > threshold_ff);

      // Grey from image B: sum of three channels over six, by reciprocal
      b_sum = {2'b00, s1_data_ff.b_red} + {2'b00, s1_data_ff.b_green} +
              {2'b00, s1_data_ff.b_blue};
      grey_prod = {10'd0, b_sum} * {10'd0, GREY_RECIP};
      grey      = grey_prod[GREY_SHIFT +: 8];

      // Saturating mismatch count
      if (bad && (bad_count_ff < BAD_CAP)) begin
         bad_count_in = bad_count_ff + BAD_TOTAL_W'(1);
      end else begin
         bad_count_in = bad_count_ff;
      end

      // Saturating difference sum; the raw sum stays below 2^34 by construction
      diff_sum   = {2'b00, diff_red} + {2'b00, diff_green} + {2'b00, diff_blue};
      abs_raw    = abs_sum_ff + ABS_TOTAL_W'(diff_sum);
      abs_sum_in = (abs_raw > ABS_CAP) ? ABS_CAP : abs_raw;

      if (bad) begin
         rsp_data_in.out_red   = MISMATCH_RED;
         rsp_data_in.out_green = diff_green;
         rsp_data_in.out_blue  = diff_blue;
      end else begin
         rsp_data_in.out_red   = grey;
         rsp_data_in.out_green = grey;
         rsp_data_in.out_blue  = grey;
      end
      rsp_data_in.pixel_bad    = bad;
      rsp_data_in.end_of_frame = s1_data_ff.frame_last;
      rsp_data_in.bad_total    = bad_count_in;
      rsp_data_in.abs_total    = abs_sum_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESHOLD_RESET;
      end else if (csr_wr_en) begin
         threshold_ff <= csr_wr_data;
      end
   end

   // Input register: take a new pixel pair on each req transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_data_ff <= req_data;
      end
   end

   // Result register: load on advance, drop once the result is transferred
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // Totals: advance with each item, clear after the end-of-frame item
   always_ff @(posedge clock) begin
      if (reset) begin
         bad_count_ff <= '0;
         abs_sum_ff   <= '0;
      end else if (advance) begin
         if (s1_data_ff.frame_last) begin
            bad_count_ff <= '0;
            abs_sum_ff   <= '0;
         end else begin
            bad_count_ff <= bad_count_in;
            abs_sum_ff   <= abs_sum_in;
         end
      end
   end

   // A frame's totals restart from zero after its last pixel
   `RIDM_ASSERT_NEXT(a_totals_clear, clock, reset,
      advance && s1_data_ff.frame_last, (bad_count_ff == '0) && (abs_sum_ff == '0))

   // Totals never pass their caps
   `RIDM_ASSERT_NOW(a_totals_capped, clock, reset,
      1'b1, (bad_count_ff <= BAD_CAP) && (abs_sum_ff <= ABS_CAP))

   // A mismatch shows full red, a match shows an even grey
   `RIDM_ASSERT_NOW(a_mask_colour, clock, reset,
      rsp_valid_ff,
      (rsp_data_ff.pixel_bad && (rsp_data_ff.out_red == MISMATCH_RED)) ||
      (!rsp_data_ff.pixel_bad && (rsp_data_ff.out_red == rsp_data_ff.out_green) &&
       (rsp_data_ff.out_green == rsp_data_ff.out_blue)))

   // A mismatch result always carries a non-zero mismatch count
   `RIDM_ASSERT_NOW(a_bad_counted, clock, reset,
      rsp_valid_ff && rsp_data_ff.pixel_bad, rsp_data_ff.bad_total != '0)

endmodule

`default_nettype wire

// File: sim/tb_rgba_image_diff_mask_unit.sv
// Self-checking testbench for the RGBA image difference mask unit.
`default_nettype none

module tb_rgba_image_diff_mask_unit;
   import ridm_pkg::*;

   logic            clock;
   logic            reset       = 1'b1;
   logic            req_valid   = 1'b0;
   logic            req_ready;
   req_payload_type req_data    = '0;
   logic            rsp_valid;
   logic            rsp_ready   = 1'b0;
   rsp_payload_type rsp_data;
   logic            csr_wr_en   = 1'b0;
   logic [7:0]      csr_wr_data = 8'd0;

   rgba_image_diff_mask_unit u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // 4-unit clock period
   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // Own copy of the block state: threshold register and the two frame totals
   logic [7:0]             mask_threshold = THRESHOLD_RESET;
   logic [BAD_TOTAL_W-1:0] mask_bad_count = '0;
   logic [ABS_TOTAL_W-1:0] mask_abs_sum   = '0;

   // Expected mask pixels, oldest first
   rsp_payload_type mask_expect_q[$];

   int  fault_count    = 0;
   int  mismatch_count = 0;
   int  pixels_sent    = 0;
   int  frames_sent    = 0;
   int  bad_seen       = 0;
   int  rsp_count      = 0;
   int  rsp_seen       = 0;
   int  stall_left     = 0;
   bit  no_idle        = 1'b0;

   // Long receiver hold-off, counted in its own process
   event hold_go;
   int   hold_len    = 0;
   bit   hold_active = 1'b0;

   function automatic logic [7:0] abs_diff(input logic [7:0] x, input logic [7:0] y);
      return (x > y) ? x - y : y - x;
   endfunction

   // Work out one mask pixel and advance the frame totals
   function automatic rsp_payload_type predict_mask(input req_payload_type px);
      logic [7:0]  d_red, d_green, d_blue, d_alpha, grey;
      logic [35:0] sum;
      logic        bad;
      rsp_payload_type r;
      d_red   = abs_diff(px.a_red,   px.b_red);
      d_green = abs_diff(px.a_green, px.b_green);
      d_blue  = abs_diff(px.a_blue,  px.b_blue);
      d_alpha = abs_diff(px.a_alpha, px.b_alpha);
      bad = (d_red > mask_threshold) || (d_green > mask_threshold) ||
            (d_blue > mask_threshold) || (d_alpha > mask_threshold);
      grey = 8'((10'(px.b_red) + 10'(px.b_green) + 10'(px.b_blue)) / 10'd6);
      if (bad) begin
         r.out_red   = MISMATCH_RED;
         r.out_green = d_green;
         r.out_blue  = d_blue;
      end else begin
         r.out_red   = grey;
         r.out_green = grey;
         r.out_blue  = grey;
      end
      if (bad && mask_bad_count < BAD_CAP)
         mask_bad_count = mask_bad_count + BAD_TOTAL_W'(1);
      // alpha makes a mismatch but never adds to the difference sum
      sum = 36'(mask_abs_sum) + 36'(d_red) + 36'(d_green) + 36'(d_blue);
      if (sum > 36'(ABS_CAP))
         sum = 36'(ABS_CAP);
      mask_abs_sum   = sum[ABS_TOTAL_W-1:0];
      r.pixel_bad    = bad;
      r.end_of_frame = px.frame_last;
      r.bad_total    = mask_bad_count;
      r.abs_total    = mask_abs_sum;
      // totals restart on the pixel after the end of frame
      if (px.frame_last) begin
         mask_bad_count = '0;
         mask_abs_sum   = '0;
      end
      return r;
   endfunction

   function automatic req_payload_type pixel_of(
      input logic [7:0] ar, ag, ab, aa, br, bg, bb, ba, input logic last);
      req_payload_type px;
      px = '{a_red: ar, a_green: ag, a_blue: ab, a_alpha: aa,
             b_red: br, b_green: bg, b_blue: bb, b_alpha: ba, frame_last: last};
      return px;
   endfunction

   // Value within spread of base, clipped to the channel range
   function automatic logic [7:0] near_value(input logic [7:0] base, input int spread);
      int offset;
      int v;
      offset = int'($urandom_range(0, 2 * spread));
      v = int'(base) + offset - spread;
      if (v < 0)
         v = 0;
      if (v > 255)
         v = 255;
      return 8'(v);
   endfunction

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         fault_count++;
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("mask mismatch on %s: expected %0d, got %0d (result %0d)",
                     name, want, got, rsp_count);
      end
   endtask

   // Compare each result transfer with the oldest expectation
   always @(posedge clock) begin
      rsp_payload_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (mask_expect_q.size() == 0) begin
            fault_count++;
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected mask result: %p", rsp_data);
         end else begin
            want = mask_expect_q.pop_front();
            check_field("out_red",      64'(want.out_red),      64'(rsp_data.out_red));
            check_field("out_green",    64'(want.out_green),    64'(rsp_data.out_green));
            check_field("out_blue",     64'(want.out_blue),     64'(rsp_data.out_blue));
            check_field("pixel_bad",    64'(want.pixel_bad),    64'(rsp_data.pixel_bad));
            check_field("end_of_frame", 64'(want.end_of_frame),
                        64'(rsp_data.end_of_frame));
            check_field("bad_total",    64'(want.bad_total),    64'(rsp_data.bad_total));
            check_field("abs_total",    64'(want.abs_total),    64'(rsp_data.abs_total));
         end
         if (rsp_data.pixel_bad)
            bad_seen++;
         rsp_count++;
      end
   end

   // Receiver: draw a stall after every result transfer, honour any hold-off
   always @(negedge clock) begin
      if (rsp_seen != rsp_count) begin
         rsp_seen   = rsp_count;
         stall_left = no_idle ? 0 : int'($urandom_range(0, 3));
      end
      if (reset || hold_active) begin
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left--;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always begin
      @(hold_go);
      @(posedge clock);
      hold_active = 1'b1;
      repeat (hold_len) @(posedge clock);
      hold_active = 1'b0;
   end

   // Offer one pixel pair and hold it until the transfer; entered and left at a
   // falling edge, with valid left high so back-to-back pixels need no toggle
   task automatic send_pixel(input req_payload_type px);
      int gap;
      gap = no_idle ? 0 : int'($urandom_range(0, 3));
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_data  <= px;
      req_valid <= 1'b1;
      do
         @(posedge clock);
      while (!req_ready);
      mask_expect_q.push_back(predict_mask(px));
      pixels_sent++;
      if (px.frame_last)
         frames_sent++;
      @(negedge clock);
   endtask

   // Drop valid and hold until every expected result has been transferred and checked
   task automatic drain_results();
      req_valid <= 1'b0;
      while (mask_expect_q.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic set_threshold(input logic [7:0] value);
      drain_results();
      csr_wr_data <= value;
      csr_wr_en   <= 1'b1;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      mask_threshold = value;
   endtask

   // Threshold out of reset is 8: probe both sides of it, alpha alone, the
   // channel extremes and frame boundaries
   task automatic test_reset_threshold();
      send_pixel(pixel_of(10, 20, 30, 40, 10, 20, 30, 40, 1'b0));
      send_pixel(pixel_of(18, 20, 30, 40, 10, 28, 22, 48, 1'b0));
      send_pixel(pixel_of(19, 20, 30, 40, 10, 20, 30, 40, 1'b0));
      send_pixel(pixel_of(50, 60, 70, 0, 50, 60, 70, 9, 1'b0));
      send_pixel(pixel_of(0, 0, 0, 0, 255, 255, 255, 255, 1'b0));
      send_pixel(pixel_of(255, 255, 255, 255, 255, 255, 255, 255, 1'b1));
      send_pixel(pixel_of(255, 255, 255, 255, 0, 0, 0, 0, 1'b1));
      send_pixel(pixel_of(1, 2, 3, 4, 5, 6, 7, 8, 1'b1));
      send_pixel(pixel_of(100, 0, 255, 128, 100, 40, 200, 128, 1'b0));
   endtask

   // Zero: any difference is a mismatch; 255: nothing ever is
   task automatic test_threshold_extremes();
      set_threshold(8'd0);
      send_pixel(pixel_of(77, 88, 99, 11, 77, 88, 99, 11, 1'b0));
      send_pixel(pixel_of(77, 88, 99, 11, 77, 88, 99, 12, 1'b0));
      send_pixel(pixel_of(0, 255, 0, 255, 255, 0, 255, 0, 1'b1));
      set_threshold(8'd255);
      send_pixel(pixel_of(0, 0, 0, 0, 255, 255, 255, 255, 1'b0));
      send_pixel(pixel_of(255, 255, 255, 255, 0, 0, 0, 0, 1'b0));
      send_pixel(pixel_of(255, 0, 255, 0, 0, 255, 0, 255, 1'b1));
   endtask

   // Frames of random length; most pixels sit close to the threshold
   task automatic test_random_frames();
      logic [7:0] phase_thr[10] = '{8'd8, 8'd0, 8'd255, 8'd1, 8'd254,
                                    8'd0, 8'd0, 8'd16, 8'd0, 8'd3};
      int         frame_left;
      int         spread;
      logic [7:0] ar, ag, ab, aa;
      logic       last;
      frame_left = 1;
      for (int phase = 0; phase < 10; phase++) begin
         if (phase == 5 || phase == 6 || phase == 8)
            phase_thr[phase] = 8'($urandom_range(0, 255));
         set_threshold(phase_thr[phase]);
         no_idle = (phase % 3 == 2);
         spread  = (int'(phase_thr[phase]) + 3 > 255) ? 255 : int'(phase_thr[phase]) + 3;
         for (int n = 0; n < 150; n++) begin
            if (frame_left == 0)
               frame_left = ($urandom_range(0, 9) == 0) ? int'($urandom_range(100, 300))
                                                        : int'($urandom_range(1, 64));
            frame_left--;
            last = (frame_left == 0);
            ar = 8'($urandom); ag = 8'($urandom); ab = 8'($urandom); aa = 8'($urandom);
            if ($urandom_range(0, 2) == 0)
               send_pixel(pixel_of(ar, ag, ab, aa, 8'($urandom), 8'($urandom),
                                   8'($urandom), 8'($urandom), last));
            else
               send_pixel(pixel_of(ar, ag, ab, aa, near_value(ar, spread),
                                   near_value(ag, spread), near_value(ab, spread),
                                   ($urandom_range(0, 1) == 0) ? aa : near_value(aa, spread),
                                   last));
         end
      end
      no_idle = 1'b0;
   endtask

   // Hold the result side off while pixels keep coming, so the unit fills up
   // and stalls its input
   task automatic test_output_hold();
      set_threshold(8'd8);
      hold_len = 150;
      -> hold_go;
      no_idle = 1'b1;
      for (int n = 0; n < 40; n++)
         send_pixel(pixel_of(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                             8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                             n == 39));
      no_idle = 1'b0;
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_reset_threshold();
      test_threshold_extremes();
      test_random_frames();
      test_output_hold();
      drain_results();

      $display("covered %0d pixel pairs in %0d frames, %0d of them mismatches",
               pixels_sent, frames_sent, bad_seen);
      $display("thresholds 0, 255, reset value and random; %0d field mismatches",
               mismatch_count);
      if (fault_count == 0 && mask_expect_q.size() == 0)
         $display("rgba_image_diff_mask_unit regression: pass");
      else
         $display("rgba_image_diff_mask_unit regression: fail");
      $finish;
   end

   // Watchdog
   initial begin
      #2000000;
      $display("rgba_image_diff_mask_unit regression: fail");
      $finish;
   end

endmodule

`default_nettype wire
